### hw/rtl/erm_pkg.sv
// Package for the Euler rotation matrix generator.
// Holds the CORDIC constants, register index codes and the product schedule.
// No dependencies.
`default_nettype none

package erm_pkg;

   // Configuration register indexes
   localparam int CSR_INDEX_BITS = 3;
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_START_X = 3'd0,
      CSR_START_Y = 3'd1,
      CSR_START_Z = 3'd2,
      CSR_STEP_X  = 3'd3,
      CSR_STEP_Y  = 3'd4,
      CSR_STEP_Z  = 3'd5
   } csr_index_type;

   // CORDIC: Q1.30 datapath, 30 rotations
   localparam int CORDIC_STEPS = 30;
   localparam int CORDIC_IT_BITS = 5;
   localparam int TRIG_BITS = 32;
   localparam int ACC_BITS = 34;
   localparam logic signed [TRIG_BITS-1:0] CORDIC_GAIN = 32'sd652032874;
   localparam logic signed [ACC_BITS-1:0] Q30_ONE = 34'sd1073741824;

   // arctan(2^-i) as a fraction of a full turn, scaled by 2^32
   function automatic logic [31:0] atan_turn(input logic [CORDIC_IT_BITS-1:0] i);
      logic [31:0] a;
      begin
         case (i)
            5'd0: a = 32'h20000000;
            5'd1: a = 32'h12E4051E;
            5'd2: a = 32'h09FB385B;
            5'd3: a = 32'h051111D4;
            5'd4: a = 32'h028B0D43;
            5'd5: a = 32'h0145D7E1;
            5'd6: a = 32'h00A2F61E;
            5'd7: a = 32'h00517C55;
            5'd8: a = 32'h0028BE53;
            5'd9: a = 32'h00145F2F;
            5'd10: a = 32'h000A2F98;
            5'd11: a = 32'h000517CC;
            5'd12: a = 32'h00028BE6;
            5'd13: a = 32'h000145F3;
            5'd14: a = 32'h0000A2FA;
            5'd15: a = 32'h0000517D;
            5'd16: a = 32'h000028BE;
            5'd17: a = 32'h0000145F;
            5'd18: a = 32'h00000A30;
            5'd19: a = 32'h00000518;
            5'd20: a = 32'h0000028C;
            5'd21: a = 32'h00000146;
            5'd22: a = 32'h000000A3;
            5'd23: a = 32'h00000051;
            5'd24: a = 32'h00000029;
            5'd25: a = 32'h00000014;
            5'd26: a = 32'h0000000A;
            5'd27: a = 32'h00000005;
            5'd28: a = 32'h00000003;
            5'd29: a = 32'h00000001;
            default: a = 32'h00000000;
         endcase
         return a;
      end
   endfunction

   // Product schedule: operands, destination and how the product is applied
   typedef enum logic [2:0] {
      OP_SX, OP_CX, OP_SY, OP_CY, OP_SZ, OP_CZ, OP_SS, OP_SC
   } operand_type;

   typedef enum logic [3:0] {
      DST_SS, DST_SC, DST_M00, DST_M01, DST_M02,
      DST_M10, DST_M11, DST_M12, DST_M21, DST_M22
   } dest_type;

   typedef enum logic [1:0] {
      MODE_SET, MODE_ADD, MODE_SUB, MODE_NEG
   } mode_type;

   typedef struct packed {
      operand_type src_a;
      operand_type src_b;
      dest_type    dst;
      mode_type    mode;
   } sched_type;

   localparam int MUL_STEPS = 14;
   localparam int MUL_STEP_BITS = 4;

   function automatic sched_type mul_sched(input logic [MUL_STEP_BITS-1:0] s);
      sched_type e;
      begin
         case (s)
            4'd0:  e = '{OP_SY, OP_SX, DST_SS,  MODE_SET};
            4'd1:  e = '{OP_SY, OP_CX, DST_SC,  MODE_SET};
            4'd2:  e = '{OP_CZ, OP_CY, DST_M00, MODE_SET};
            4'd3:  e = '{OP_CZ, OP_SS, DST_M01, MODE_SET};
            4'd4:  e = '{OP_SZ, OP_CX, DST_M01, MODE_ADD};
            4'd5:  e = '{OP_CZ, OP_SC, DST_M02, MODE_SET};
            4'd6:  e = '{OP_SZ, OP_SX, DST_M02, MODE_SUB};
            4'd7:  e = '{OP_SZ, OP_CY, DST_M10, MODE_NEG};
            4'd8:  e = '{OP_SZ, OP_SS, DST_M11, MODE_NEG};
            4'd9:  e = '{OP_CZ, OP_CX, DST_M11, MODE_ADD};
            4'd10: e = '{OP_SZ, OP_SC, DST_M12, MODE_NEG};
            4'd11: e = '{OP_CZ, OP_SX, DST_M12, MODE_SUB};
            4'd12: e = '{OP_CY, OP_SX, DST_M21, MODE_SET};
            4'd13: e = '{OP_CY, OP_CX, DST_M22, MODE_SET};
            default: e = '{OP_SX, OP_SX, DST_SS, MODE_SET};
         endcase
         return e;
      end
   endfunction

endpackage

`default_nettype wire

### hw/rtl/erm_if.sv
// Valid/ready channel interfaces for the rotation matrix generator.
// Request carries the restart flag; response carries one matrix element.
`default_nettype none

interface erm_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

interface erm_rsp_if #(
   parameter int VALUE_BITS = 16
);
   logic                         valid;
   logic                         ready;
   logic [3:0]                   element_index;
   logic signed [VALUE_BITS-1:0] element_value;
   logic                         last;

   modport source (output valid, output element_index, output element_value,
                   output last, input ready);
   modport sink (input valid, input element_index, input element_value,
                 input last, output ready);
endinterface

`default_nettype wire

### hw/rtl/erm_cordic.sv
// Iterative rotation-mode CORDIC: one rotation per cycle, sine and cosine in Q1.30.
// Depends on erm_pkg.
`default_nettype none

module erm_cordic #(
   parameter int ANGLE_BITS = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   input  wire logic [ANGLE_BITS-1:0]                 phase,
   output logic                                       done,
   output logic signed [erm_pkg::TRIG_BITS-1:0]       sin_q,
   output logic signed [erm_pkg::TRIG_BITS-1:0]       cos_q
);
   import erm_pkg::*;

   logic signed [ACC_BITS-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [CORDIC_IT_BITS-1:0]  it_ff, it_in;
   logic                       busy_ff, busy_in, done_ff, done_in, flip_ff, flip_in;
   logic [31:0]                u, u_rot;
   logic                       flip;
   logic signed [ACC_BITS-1:0] x_sh, y_sh, atan_s;

   // fold the phase into [-90,90) degrees
   assign u     = 32'(phase) << (32 - ANGLE_BITS);
   assign flip  = u[31] ^ u[30];
   assign u_rot = {u[31] ^ flip, u[30:0]};

   assign x_sh   = x_ff >>> it_ff;
   assign y_sh   = y_ff >>> it_ff;
   assign atan_s = signed'({2'b00, atan_turn(it_ff)});

   // rotation step
   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      it_in   = it_ff;
      busy_in = busy_ff;
      flip_in = flip_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = ACC_BITS'(CORDIC_GAIN);
         y_in    = '0;
         z_in    = ACC_BITS'(signed'(u_rot));
         it_in   = '0;
         busy_in = 1'b1;
         flip_in = flip;
      end else if (busy_ff) begin
         if (!z_ff[ACC_BITS-1]) begin
            x_in = x_ff - y_sh;
            y_in = y_ff + x_sh;
            z_in = z_ff - atan_s;
         end else begin
            x_in = x_ff + y_sh;
            y_in = y_ff - x_sh;
            z_in = z_ff + atan_s;
         end
         it_in = it_ff + 1'b1;
         if (it_ff == CORDIC_IT_BITS'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      it_ff   <= it_in;
      flip_ff <= flip_in;
   end

   assign done  = done_ff;
   assign sin_q = TRIG_BITS'(flip_ff ? -y_ff : y_ff);
   assign cos_q = TRIG_BITS'(flip_ff ? -x_ff : x_ff);

endmodule

`default_nettype wire

### hw/rtl/euler_rotation_matrix_generator.sv
// Euler rotation matrix generator: top level, sequencer, shared multiplier.
// Depends on erm_pkg, erm_if (erm_req_if, erm_rsp_if) and erm_cordic.
//
// Usage: each request transaction on req_if (restart flag) produces one frame
// of 16 response transactions on rsp_if: the elements of M = Rz*Ry*Rx in
// column-major order, Q2.14 saturated to +-1, last set on the sixteenth.
// With restart set the angles are reloaded from the start registers first;
// after each frame every angle advances by its step, wrapping at a full turn.
// Registers are written on csr_wr_en with csr_index 0..5 (start x/y/z,
// step x/y/z); other indexes are ignored. Write only while the block is idle.
// Sequence: one request runs the three angles through the CORDIC in turn (30
// rotations each, after a load state and before a result wait), then the 14
// products through the multiplier (a multiply and an accumulate state each),
// then emits the 16 elements; a new request is taken only once the frame has
// been emitted. The shared CORDIC and multiplier set this.
// req_if.ready is high only while no frame is in progress.
// A stalled receiver holds the current element in the output register and
// the sequencer waits. Reset (synchronous) loads the register reset values,
// the angles from the start reset values, and empties the output.
`default_nettype none

module euler_rotation_matrix_generator #(
   parameter int FRAC_BITS  = 14,
   parameter int ANGLE_BITS = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   erm_req_if.sink                                 req_if,
   erm_rsp_if.source                               rsp_if,
   input  wire logic                               csr_wr_en,
   input  wire logic [erm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [ANGLE_BITS-1:0]              csr_wdata
);
   import erm_pkg::*;

   localparam int VALUE_BITS = FRAC_BITS + 2;
   localparam int OUT_SHIFT  = 30 - FRAC_BITS;
   localparam int WIDE_BITS  = ACC_BITS + 2;
   localparam logic signed [WIDE_BITS-1:0] ROUND_ADD =
      (OUT_SHIFT > 0) ? (WIDE_BITS'(1) << ((OUT_SHIFT > 0) ? OUT_SHIFT - 1 : 0)) : '0;
   localparam logic signed [WIDE_BITS-1:0] LIMIT = WIDE_BITS'(1) << FRAC_BITS;

   typedef enum logic [2:0] {
      ST_IDLE, ST_TRIG, ST_TWAIT, ST_MULA, ST_MULB, ST_EMIT
   } state_type;

   typedef logic signed [TRIG_BITS-1:0] trig_type;
   typedef logic signed [ACC_BITS-1:0]  acc_type;

   // configuration registers
   logic [ANGLE_BITS-1:0] start_x_ff, start_y_ff, start_z_ff;
   logic [ANGLE_BITS-1:0] step_x_ff, step_y_ff, step_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff <= ANGLE_BITS'(0);
         start_y_ff <= ANGLE_BITS'(8192);
         start_z_ff <= ANGLE_BITS'(1820);
         step_x_ff  <= ANGLE_BITS'(46);
         step_y_ff  <= ANGLE_BITS'(-91);
         step_z_ff  <= ANGLE_BITS'(27);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_START_X: start_x_ff <= csr_wdata;
            CSR_START_Y: start_y_ff <= csr_wdata;
            CSR_START_Z: start_z_ff <= csr_wdata;
            CSR_STEP_X:  step_x_ff  <= csr_wdata;
            CSR_STEP_Y:  step_y_ff  <= csr_wdata;
            CSR_STEP_Z:  step_z_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   state_type state_ff, state_in;
   logic [ANGLE_BITS-1:0] angle_x_ff, angle_x_in, angle_y_ff, angle_y_in;
   logic [ANGLE_BITS-1:0] angle_z_ff, angle_z_in;
   logic [ANGLE_BITS-1:0] work_x_ff, work_x_in, work_y_ff, work_y_in;
   logic [ANGLE_BITS-1:0] work_z_ff, work_z_in;
   logic [1:0]            axis_ff, axis_in;
   logic [MUL_STEP_BITS-1:0] step_ff, step_in;
   logic [3:0]            elem_ff, elem_in;
   trig_type sx_ff, sx_in, cx_ff, cx_in, sy_ff, sy_in, cy_ff, cy_in;
   trig_type sz_ff, sz_in, cz_ff, cz_in;
   acc_type  ss_ff, ss_in, sc_ff, sc_in;
   acc_type  m00_ff, m00_in, m01_ff, m01_in, m02_ff, m02_in;
   acc_type  m10_ff, m10_in, m11_ff, m11_in, m12_ff, m12_in;
   acc_type  m21_ff, m21_in, m22_ff, m22_in;
   logic signed [2*TRIG_BITS-1:0] prod_ff, prod_in;
   logic     out_valid_ff, out_valid_in, out_last_ff, out_last_in;
   logic [3:0] out_index_ff, out_index_in;
   logic signed [VALUE_BITS-1:0] out_value_ff, out_value_in;

   logic       cordic_start, cordic_done;
   logic [ANGLE_BITS-1:0] cordic_phase;
   trig_type   cordic_sin, cordic_cos;
   sched_type  sched;
   trig_type   op_a, op_b, cur;
   logic signed [2*TRIG_BITS-1:0] prod_round;
   acc_type    rounded, cur_acc, applied, elem_sel;
   logic signed [WIDE_BITS-1:0] elem_wide, elem_shift;
   logic signed [VALUE_BITS-1:0] elem_out;
   logic       req_fire, out_free;

   erm_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .phase (cordic_phase),
      .done  (cordic_done),
      .sin_q (cordic_sin),
      .cos_q (cordic_cos)
   );

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_if.valid && (state_ff == ST_IDLE);
   assign out_free     = !out_valid_ff || rsp_if.ready;
   assign cordic_start = (state_ff == ST_TRIG);
   assign cordic_phase = (axis_ff == 2'd0) ? work_x_ff :
                         (axis_ff == 2'd1) ? work_y_ff : work_z_ff;

   // operand selection for the shared multiplier
   assign sched = mul_sched(step_ff);

   function automatic trig_type pick(input operand_type o, input trig_type sx,
                                     input trig_type cx, input trig_type sy,
                                     input trig_type cy, input trig_type sz,
                                     input trig_type cz, input acc_type ss,
                                     input acc_type sc);
      trig_type r;
      begin
         case (o)
            OP_SX: r = sx;
            OP_CX: r = cx;
            OP_SY: r = sy;
            OP_CY: r = cy;
            OP_SZ: r = sz;
            OP_CZ: r = cz;
            OP_SS: r = TRIG_BITS'(ss);
            OP_SC: r = TRIG_BITS'(sc);
            default: r = sx;
         endcase
         return r;
      end
   endfunction

   assign op_a = pick(sched.src_a, sx_ff, cx_ff, sy_ff, cy_ff, sz_ff, cz_ff, ss_ff, sc_ff);
   assign op_b = pick(sched.src_b, sx_ff, cx_ff, sy_ff, cy_ff, sz_ff, cz_ff, ss_ff, sc_ff);
   assign cur  = '0;

   // round the product to Q1.30 and fold it into the destination
   assign prod_round = prod_ff + (2*TRIG_BITS)'(Q30_ONE >>> 1);
   assign rounded    = ACC_BITS'(prod_round >>> 30);

   always_comb begin
      case (sched.dst)
         DST_SS:  cur_acc = ss_ff;
         DST_SC:  cur_acc = sc_ff;
         DST_M00: cur_acc = m00_ff;
         DST_M01: cur_acc = m01_ff;
         DST_M02: cur_acc = m02_ff;
         DST_M10: cur_acc = m10_ff;
         DST_M11: cur_acc = m11_ff;
         DST_M12: cur_acc = m12_ff;
         DST_M21: cur_acc = m21_ff;
         DST_M22: cur_acc = m22_ff;
         default: cur_acc = ACC_BITS'(cur);
      endcase
      case (sched.mode)
         MODE_SET: applied = rounded;
         MODE_ADD: applied = cur_acc + rounded;
         MODE_SUB: applied = cur_acc - rounded;
         MODE_NEG: applied = -rounded;
         default:  applied = rounded;
      endcase
   end

   // element k is M[k mod 4][k div 4]
   always_comb begin
      case (elem_ff)
         4'd0:  elem_sel = m00_ff;
         4'd1:  elem_sel = m10_ff;
         4'd2:  elem_sel = -ACC_BITS'(sy_ff);
         4'd4:  elem_sel = m01_ff;
         4'd5:  elem_sel = m11_ff;
         4'd6:  elem_sel = m21_ff;
         4'd8:  elem_sel = m02_ff;
         4'd9:  elem_sel = m12_ff;
         4'd10: elem_sel = m22_ff;
         4'd15: elem_sel = Q30_ONE;
         default: elem_sel = '0;
      endcase
   end

   // round to the output fraction and saturate to +-1
   assign elem_wide  = WIDE_BITS'(elem_sel) + ROUND_ADD;
   assign elem_shift = elem_wide >>> OUT_SHIFT;
   assign elem_out   = (elem_shift > LIMIT) ? VALUE_BITS'(LIMIT) :
                       (elem_shift < -LIMIT) ? VALUE_BITS'(-LIMIT) :
                       VALUE_BITS'(elem_shift);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      angle_x_in   = angle_x_ff;
      angle_y_in   = angle_y_ff;
      angle_z_in   = angle_z_ff;
      work_x_in    = work_x_ff;
      work_y_in    = work_y_ff;
      work_z_in    = work_z_ff;
      axis_in      = axis_ff;
      step_in      = step_ff;
      elem_in      = elem_ff;
      sx_in = sx_ff; cx_in = cx_ff; sy_in = sy_ff;
      cy_in = cy_ff; sz_in = sz_ff; cz_in = cz_ff;
      ss_in = ss_ff; sc_in = sc_ff;
      m00_in = m00_ff; m01_in = m01_ff; m02_in = m02_ff;
      m10_in = m10_ff; m11_in = m11_ff; m12_in = m12_ff;
      m21_in = m21_ff; m22_in = m22_ff;
      prod_in      = prod_ff;
      out_valid_in = out_valid_ff && !rsp_if.ready;
      out_index_in = out_index_ff;
      out_value_in = out_value_ff;
      out_last_in  = out_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               work_x_in  = req_if.restart ? start_x_ff : angle_x_ff;
               work_y_in  = req_if.restart ? start_y_ff : angle_y_ff;
               work_z_in  = req_if.restart ? start_z_ff : angle_z_ff;
               angle_x_in = work_x_in + step_x_ff;
               angle_y_in = work_y_in + step_y_ff;
               angle_z_in = work_z_in + step_z_ff;
               axis_in    = 2'd0;
               state_in   = ST_TRIG;
            end
         end
         ST_TRIG: state_in = ST_TWAIT;
         ST_TWAIT: begin
            if (cordic_done) begin
               case (axis_ff)
                  2'd0: begin sx_in = cordic_sin; cx_in = cordic_cos; end
                  2'd1: begin sy_in = cordic_sin; cy_in = cordic_cos; end
                  default: begin sz_in = cordic_sin; cz_in = cordic_cos; end
               endcase
               if (axis_ff == 2'd2) begin
                  step_in  = '0;
                  state_in = ST_MULA;
               end else begin
                  axis_in  = axis_ff + 1'b1;
                  state_in = ST_TRIG;
               end
            end
         end
         ST_MULA: begin
            prod_in  = op_a * op_b;
            state_in = ST_MULB;
         end
         ST_MULB: begin
            case (sched.dst)
               DST_SS:  ss_in  = applied;
               DST_SC:  sc_in  = applied;
               DST_M00: m00_in = applied;
               DST_M01: m01_in = applied;
               DST_M02: m02_in = applied;
               DST_M10: m10_in = applied;
               DST_M11: m11_in = applied;
               DST_M12: m12_in = applied;
               DST_M21: m21_in = applied;
               DST_M22: m22_in = applied;
               default: ;
            endcase
            if (step_ff == MUL_STEP_BITS'(MUL_STEPS - 1)) begin
               elem_in  = '0;
               state_in = ST_EMIT;
            end else begin
               step_in  = step_ff + 1'b1;
               state_in = ST_MULA;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_index_in = elem_ff;
               out_value_in = elem_out;
               out_last_in  = (elem_ff == 4'd15);
               elem_in      = elem_ff + 1'b1;
               if (elem_ff == 4'd15) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         angle_x_ff   <= ANGLE_BITS'(0);
         angle_y_ff   <= ANGLE_BITS'(8192);
         angle_z_ff   <= ANGLE_BITS'(1820);
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         angle_x_ff   <= angle_x_in;
         angle_y_ff   <= angle_y_in;
         angle_z_ff   <= angle_z_in;
      end
      work_x_ff <= work_x_in;
      work_y_ff <= work_y_in;
      work_z_ff <= work_z_in;
      axis_ff   <= axis_in;
      step_ff   <= step_in;
      elem_ff   <= elem_in;
      sx_ff <= sx_in; cx_ff <= cx_in; sy_ff <= sy_in;
      cy_ff <= cy_in; sz_ff <= sz_in; cz_ff <= cz_in;
      ss_ff <= ss_in; sc_ff <= sc_in;
      m00_ff <= m00_in; m01_ff <= m01_in; m02_ff <= m02_in;
      m10_ff <= m10_in; m11_ff <= m11_in; m12_ff <= m12_in;
      m21_ff <= m21_in; m22_ff <= m22_in;
      prod_ff      <= prod_in;
      out_index_ff <= out_index_in;
      out_value_ff <= out_value_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.element_index = out_index_ff;
   assign rsp_if.element_value = out_value_ff;
   assign rsp_if.last          = out_last_ff;

endmodule

`default_nettype wire

### dv/tb_euler_rotation_matrix_generator.sv
// Testbench for the Euler rotation matrix generator.
// It predicts every matrix element with its own CORDIC and product chain and
// checks each response transaction. Depends on erm_pkg, erm_if and the RTL.
`default_nettype none

module tb_euler_rotation_matrix_generator;
   import erm_pkg::*;

   localparam int VALUE_BITS   = 16;
   localparam int ELEMENTS     = 16;
   localparam int STALL_LIMIT  = 6000;
   localparam int SETTLE_TICKS = 200;
   localparam int RANDOM_ITEMS = 380;
   // indexes past the register file, which the block must ignore
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_A = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_B = 3'd7;

   localparam longint ROT_GAIN = 64'sd652032874;
   localparam longint ONE_Q30  = 64'sd1073741824;
   localparam longint ELEM_MAX = 64'sd16384;

   // arctan(2^-i) in turns scaled by 2^32
   localparam longint ARC_TURN [0:29] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
      64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
      64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
      64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001};

   typedef struct packed {
      logic [3:0]                   index;
      logic signed [VALUE_BITS-1:0] value;
      logic                         last;
   } element_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [15:0] csr_wdata;

   erm_req_if req_if ();
   erm_rsp_if #(.VALUE_BITS(VALUE_BITS)) rsp_if ();

   euler_rotation_matrix_generator dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor state
   logic [15:0] start_x, start_y, start_z;
   logic [15:0] step_x, step_y, step_z;
   logic [15:0] phase_x, phase_y, phase_z;
   element_type pending_elements[$];
   int          error_count;
   bit          gaps_enabled;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint qmul(input longint a, input longint b);
      return (a * b + (ONE_Q30 >>> 1)) >>> 30;
   endfunction

   // rotation-mode CORDIC with half-turn folding
   task automatic sin_cos(input logic [15:0] phase, output longint s, output longint c);
      logic [31:0] u;
      logic [31:0] probe;
      bit          fold;
      longint      x, y, z, nx;
      u = {phase, 16'h0000};
      probe = u + 32'h40000000;
      fold = probe[31];
      if (fold) u = u ^ 32'h80000000;
      z = longint'($signed(u));
      x = ROT_GAIN;
      y = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z = z - ARC_TURN[i];
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z = z + ARC_TURN[i];
         end
         x = nx;
      end
      s = fold ? -y : y;
      c = fold ? -x : x;
   endtask

   function automatic logic [VALUE_BITS-1:0] to_q14(input longint v);
      longint r;
      r = (v + 64'sd32768) >>> 16;
      if (r > ELEM_MAX) r = ELEM_MAX;
      if (r < -ELEM_MAX) r = -ELEM_MAX;
      return r[VALUE_BITS-1:0];
   endfunction

   // queue the 16 elements of one frame, then advance the phases
   task automatic predict_frame(input bit restart);
      longint sx, cx, sy, cy, sz, cz, ss, sc;
      longint m[4][4];
      element_type e;
      if (restart) begin
         phase_x = start_x;
         phase_y = start_y;
         phase_z = start_z;
      end
      sin_cos(phase_x, sx, cx);
      sin_cos(phase_y, sy, cy);
      sin_cos(phase_z, sz, cz);
      ss = qmul(sy, sx);
      sc = qmul(sy, cx);
      foreach (m[r, c]) m[r][c] = 0;
      m[0][0] = qmul(cz, cy);
      m[0][1] = qmul(cz, ss) + qmul(sz, cx);
      m[0][2] = qmul(cz, sc) - qmul(sz, sx);
      m[1][0] = -qmul(sz, cy);
      m[1][1] = -qmul(sz, ss) + qmul(cz, cx);
      m[1][2] = -qmul(sz, sc) - qmul(cz, sx);
      m[2][0] = -sy;
      m[2][1] = qmul(cy, sx);
      m[2][2] = qmul(cy, cx);
      m[3][3] = ONE_Q30;
      for (int k = 0; k < ELEMENTS; k++) begin
         e.index = k[3:0];
         e.value = to_q14(m[k % 4][k / 4]);
         e.last  = (k == ELEMENTS - 1);
         pending_elements.push_back(e);
      end
      phase_x = phase_x + step_x;
      phase_y = phase_y + step_y;
      phase_z = phase_z + step_z;
   endtask

   function automatic int gap_length();
      int pick;
      if (!gaps_enabled) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 70) return $urandom_range(0, 2);
      if (pick < 95) return $urandom_range(3, 10);
      return $urandom_range(20, 60);
   endfunction

   // one request transaction
   task automatic send_frame(input bit restart);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.restart <= restart;
      do @(posedge clock); while (!req_if.ready);
      predict_frame(restart);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (pending_elements.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // register write while idle
   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx, input logic [15:0] data);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_START_X: start_x = data;
         CSR_START_Y: start_y = data;
         CSR_START_Z: start_z = data;
         CSR_STEP_X:  step_x  = data;
         CSR_STEP_Y:  step_y  = data;
         CSR_STEP_Z:  step_z  = data;
         default: ;
      endcase
   endtask

   task automatic write_all(input logic [15:0] ax, ay, az, dx, dy, dz);
      write_csr(CSR_START_X, ax);
      write_csr(CSR_START_Y, ay);
      write_csr(CSR_START_Z, az);
      write_csr(CSR_STEP_X, dx);
      write_csr(CSR_STEP_Y, dy);
      write_csr(CSR_STEP_Z, dz);
   endtask

   // reset register values, free-running angles, then one restart
   task automatic test_default_frames();
      repeat (4) send_frame(1'b0);
      send_frame(1'b1);
   endtask

   // quadrant edges, fold boundaries, extreme steps and wrap-around
   task automatic test_angle_extremes();
      write_all(16'd0, 16'd16383, 16'd16384, 16'h7FFF, 16'h8000, 16'hFFFF);
      repeat (3) send_frame(1'b0);
      send_frame(1'b1);
      write_all(16'd49151, 16'd49152, 16'd65535, 16'd1, 16'd0, 16'h8000);
      send_frame(1'b1);
      repeat (3) send_frame(1'b0);
      write_all(16'd32768, 16'd32767, 16'd8192, 16'h8001, 16'h7FFF, 16'd16384);
      send_frame(1'b1);
      repeat (3) send_frame(1'b0);
   endtask

   // writes past the register file leave everything unchanged
   task automatic test_ignored_index();
      write_csr(CSR_UNUSED_A, 16'hFFFF);
      write_csr(CSR_UNUSED_B, 16'h5A5A);
      send_frame(1'b1);
      send_frame(1'b0);
   endtask

   // random settings per phase, mostly free running with some restarts
   task automatic test_random_frames();
      int sent;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         write_all(16'($urandom()), 16'($urandom()), 16'($urandom()),
                   16'($urandom()), 16'($urandom()), 16'($urandom()));
         gaps_enabled = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(10, 40)) begin
            send_frame($urandom_range(0, 9) == 0);
            sent++;
         end
      end
      gaps_enabled = 1'b1;
   endtask

   // receiver stalls
   int stall_left;
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_if.ready <= 1'b0;
      end else if (gaps_enabled && $urandom_range(0, 3) == 0) begin
         stall_left <= gap_length();
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // response check against the oldest expectation
   always @(posedge clock) begin
      element_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_elements.size() == 0) begin
            $display("%0t: element %0d arrived with none expected", $time,
                     rsp_if.element_index);
            error_count++;
         end else begin
            want = pending_elements.pop_front();
            if (rsp_if.element_index !== want.index || rsp_if.element_value !== want.value ||
                rsp_if.last !== want.last) begin
               $display("%0t: expected index %0d value %0d last %0b, got %0d %0d %0b",
                        $time, want.index, want.value, want.last, rsp_if.element_index,
                        rsp_if.element_value, rsp_if.last);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles with no transaction
   int quiet_cycles;
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("euler_rotation_matrix_generator: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      error_count  = 0;
      gaps_enabled = 1'b1;
      start_x = 16'd0;
      start_y = 16'd8192;
      start_z = 16'd1820;
      step_x  = 16'd46;
      step_y  = -16'sd91;
      step_z  = 16'd27;
      phase_x = start_x;
      phase_y = start_y;
      phase_z = start_z;
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.restart <= 1'b0;
      csr_wr_en      <= 1'b0;
      csr_index      <= CSR_START_X;
      csr_wdata      <= 16'd0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_default_frames();
      test_angle_extremes();
      test_ignored_index();
      test_random_frames();
      wait_drained();
      repeat (SETTLE_TICKS) @(posedge clock);
      if (error_count == 0) begin
         $display("euler_rotation_matrix_generator: match");
      end else begin
         $display("euler_rotation_matrix_generator: mismatch");
      end
      $finish;
   end

endmodule

`default_nettype wire
